>>> hdl/crcfr_pkg.sv
// Package for the CRC-checked frame receiver: constants, the frame result type
// and the CRC-16 byte update function. No dependencies.
`default_nettype none

package crcfr_pkg;

   localparam logic [7:0]  START_BYTE = 8'h3C;
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;

   localparam logic [3:0] POS_HUNT     = 4'd0;
   localparam logic [3:0] POS_LAST_HDR = 4'd6;
   localparam logic [3:0] POS_CRC_HI   = 4'd7;
   localparam logic [3:0] POS_CRC_LO   = 4'd8;

   typedef struct packed {
      logic [7:0]  frame_address;
      logic [7:0]  frame_command;
      logic [15:0] first_word;
      logic [15:0] second_word;
      logic        crc_ok;
      logic        address_match;
      logic [15:0] bad_start_count;
      logic [15:0] line_error_count;
   } frame_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

>>> hdl/crcfr_channels.sv
// Valid/ready channel interfaces for received bytes and completed frames.
// No dependencies.
`default_nettype none

interface crcfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       line_error;
   modport source (output valid, output rx_byte, output line_error, input ready);
   modport sink (input valid, input rx_byte, input line_error, output ready);
endinterface

interface crcfr_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  frame_address;
   logic [7:0]  frame_command;
   logic [15:0] first_word;
   logic [15:0] second_word;
   logic        crc_ok;
   logic        address_match;
   logic [15:0] bad_start_count;
   logic [15:0] line_error_count;
   modport source (output valid, output frame_address, output frame_command,
                   output first_word, output second_word, output crc_ok,
                   output address_match, output bad_start_count,
                   output line_error_count, input ready);
   modport sink (input valid, input frame_address, input frame_command,
                 input first_word, input second_word, input crc_ok,
                 input address_match, input bad_start_count,
                 input line_error_count, output ready);
endinterface

`default_nettype wire

>>> hdl/crc_checked_frame_receiver.sv
// Top level of the CRC-checked frame receiver: node address register,
// deframer and result register. Depends on crcfr_pkg, crcfr_channels,
// crcfr_deframer and crcfr_out_stage.
//
// Usage: received serial bytes enter on req_if, one transaction per byte with
// its line-error flag. The block hunts for the start byte, collects address,
// command, two big-endian data words and a big-endian CRC-16, and after the
// ninth byte sends one transaction on rsp_if with the frame fields, the CRC
// and address checks and both error counters. Other bytes give no result.
// The user must write the node address by csr_write_enable and csr_write_data
// while no frame result is pending; the block does not enforce this.
// The result is valid in the cycle after the ninth byte is accepted.
// Throughput: one byte per cycle unless a held result stalls rsp_if, set by
// the combinational CRC byte update and the one result register.
// Reset clears the node address and both counters and starts hunting.
// When rsp_if is stalled with a result held, req_if.ready drops until that
// result is taken; otherwise bytes are taken every cycle.
`default_nettype none

module crc_checked_frame_receiver (
   input  wire logic       clock,
   input  wire logic       reset,
   crcfr_req_if.sink       req_if,
   crcfr_rsp_if.source     rsp_if,
   input  wire logic       csr_write_enable,
   input  wire logic [7:0] csr_write_data
);

   logic [7:0]           node_addr_ff;
   logic                 can_accept;
   logic                 accept;
   logic                 frame_valid;
   crcfr_pkg::frame_type frame;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_addr_ff <= '0;
      end else if (csr_write_enable) begin
         node_addr_ff <= csr_write_data;
      end
   end

   assign req_if.ready = can_accept;
   assign accept       = req_if.valid && can_accept;

   crcfr_deframer u_deframer (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .rx_byte      (req_if.rx_byte),
      .line_error   (req_if.line_error),
      .node_address (node_addr_ff),
      .frame_valid  (frame_valid),
      .frame        (frame)
   );

   crcfr_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .frame_valid (frame_valid),
      .frame       (frame),
      .can_accept  (can_accept),
      .rsp_if      (rsp_if)
   );

endmodule

`default_nettype wire

>>> hdl/crcfr_deframer.sv
// Frame assembly state, CRC-16 accumulation and error counters.
// Depends on crcfr_pkg.
`default_nettype none

module crcfr_deframer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [7:0]          rx_byte,
   input  wire logic                line_error,
   input  wire logic [7:0]          node_address,
   output logic                     frame_valid,
   output crcfr_pkg::frame_type     frame
);

   logic [3:0]  pos_ff, pos_in;
   logic [47:0] header_ff, header_in;
   logic [7:0]  crc_hi_ff, crc_hi_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] bad_ff, bad_in;
   logic [15:0] lerr_ff, lerr_in;

   always_comb begin
      pos_in      = pos_ff;
      header_in   = header_ff;
      crc_hi_in   = crc_hi_ff;
      crc_in      = crc_ff;
      bad_in      = bad_ff;
      lerr_in     = lerr_ff;
      frame_valid = 1'b0;
      if (accept) begin
         if (line_error) begin
            lerr_in = lerr_ff + 16'd1;
            pos_in  = crcfr_pkg::POS_HUNT;
         end else if (pos_ff == crcfr_pkg::POS_HUNT || pos_ff > crcfr_pkg::POS_CRC_LO) begin
            if (rx_byte == crcfr_pkg::START_BYTE) begin
               pos_in = 4'd1;
               crc_in = crcfr_pkg::CRC_INIT;
            end else begin
               pos_in = crcfr_pkg::POS_HUNT;
               bad_in = bad_ff + 16'd1;
            end
         end else if (pos_ff <= crcfr_pkg::POS_LAST_HDR) begin
            header_in = {header_ff[39:0], rx_byte};
            crc_in    = crcfr_pkg::crc_feed(crc_ff, rx_byte);
            pos_in    = pos_ff + 4'd1;
         end else if (pos_ff == crcfr_pkg::POS_CRC_HI) begin
            crc_hi_in = rx_byte;
            pos_in    = crcfr_pkg::POS_CRC_LO;
         end else begin
            frame_valid = 1'b1;
            pos_in      = crcfr_pkg::POS_HUNT;
         end
      end
   end

   always_comb begin
      frame.frame_address    = header_ff[47:40];
      frame.frame_command    = header_ff[39:32];
      frame.first_word       = header_ff[31:16];
      frame.second_word      = header_ff[15:0];
      frame.crc_ok           = ({crc_hi_ff, rx_byte} == crc_ff);
      frame.address_match    = (header_ff[47:40] == node_address);
      frame.bad_start_count  = bad_ff;
      frame.line_error_count = lerr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= crcfr_pkg::POS_HUNT;
         header_ff <= '0;
         crc_hi_ff <= '0;
         crc_ff    <= crcfr_pkg::CRC_INIT;
         bad_ff    <= '0;
         lerr_ff   <= '0;
      end else begin
         pos_ff    <= pos_in;
         header_ff <= header_in;
         crc_hi_ff <= crc_hi_in;
         crc_ff    <= crc_in;
         bad_ff    <= bad_in;
         lerr_ff   <= lerr_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/crcfr_out_stage.sv
// Result register between the deframer and the frame channel; it also
// derives input readiness. Depends on crcfr_pkg and crcfr_channels.
`default_nettype none

module crcfr_out_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                frame_valid,
   input  wire crcfr_pkg::frame_type frame,
   output logic                     can_accept,
   crcfr_rsp_if.source              rsp_if
);

   logic                 valid_ff, valid_in;
   crcfr_pkg::frame_type data_ff, data_in;

   assign can_accept = !valid_ff || rsp_if.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (valid_ff && rsp_if.ready) begin
         valid_in = 1'b0;
      end
      if (frame_valid) begin
         valid_in = 1'b1;
         data_in  = frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_if.valid            = valid_ff;
   assign rsp_if.frame_address    = data_ff.frame_address;
   assign rsp_if.frame_command    = data_ff.frame_command;
   assign rsp_if.first_word       = data_ff.first_word;
   assign rsp_if.second_word      = data_ff.second_word;
   assign rsp_if.crc_ok           = data_ff.crc_ok;
   assign rsp_if.address_match    = data_ff.address_match;
   assign rsp_if.bad_start_count  = data_ff.bad_start_count;
   assign rsp_if.line_error_count = data_ff.line_error_count;

endmodule

`default_nettype wire

>>> tb/tb_crc_checked_frame_receiver.sv
// Self-checking testbench for crc_checked_frame_receiver: a directed frame table, then random
// frames, noise and broken frames under varying back-pressure, checked against a deframer model.
// Depends on crcfr_pkg, crcfr_channels and the receiver RTL.
module tb_crc_checked_frame_receiver;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned LONG_STALL    = 400;
   localparam int unsigned PHASE_BYTES   = 580;

   typedef enum logic [1:0] {SRC_LITERAL, SRC_CRC_HIGH, SRC_CRC_LOW, SRC_CRC_LOW_BAD}
      byte_source_type;

   typedef struct {
      byte_source_type      source;
      logic [7:0]           value;
      logic                 line_err;
      bit                   has_frame;
      crcfr_pkg::frame_type frame;
   } directed_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable;
   logic [7:0] csr_write_data;

   crcfr_req_if req_ch();
   crcfr_rsp_if rsp_ch();

   crc_checked_frame_receiver uut (
      .clock(clock),
      .reset(reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   logic [3:0]  frame_pos = crcfr_pkg::POS_HUNT;
   logic [47:0] header_bits = '0;
   logic [7:0]  crc_hi_seen = '0;
   logic [15:0] crc_acc = crcfr_pkg::CRC_INIT;
   logic [15:0] bad_start_tally = '0;
   logic [15:0] line_error_tally = '0;
   logic [7:0]  node_addr = '0;

   crcfr_pkg::frame_type pending_frames[$];

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned bytes_sent = 0;
   int unsigned frames_checked = 0;
   int unsigned crc_fail_frames = 0;
   int unsigned addressed_frames = 0;
   int unsigned stall_requests = 0;
   int unsigned stalls_served = 0;
   int unsigned send_gap_pct = 0;
   int unsigned recv_gap_pct = 0;

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d frames outstanding",
                  cycle_count, pending_frames.size());
         $display("tb_crc_checked_frame_receiver: errors");
         $finish;
      end
   end

   function automatic crcfr_pkg::frame_type frame_of(input logic [7:0] addr,
                                                     input logic [7:0] cmd,
                                                     input logic [15:0] w1,
                                                     input logic [15:0] w2,
                                                     input logic ok, input logic match,
                                                     input logic [15:0] bad,
                                                     input logic [15:0] lerr);
      crcfr_pkg::frame_type f;
      f.frame_address    = addr;
      f.frame_command    = cmd;
      f.first_word       = w1;
      f.second_word      = w2;
      f.crc_ok           = ok;
      f.address_match    = match;
      f.bad_start_count  = bad;
      f.line_error_count = lerr;
      return f;
   endfunction

   function automatic directed_row_type mk_row(input byte_source_type source,
                                               input logic [7:0] value,
                                               input logic line_err, input bit has_frame,
                                               input crcfr_pkg::frame_type frame);
      directed_row_type r;
      r.source    = source;
      r.value     = value;
      r.line_err  = line_err;
      r.has_frame = has_frame;
      r.frame     = frame;
      return r;
   endfunction

   // Bit-serial form of the reflected CRC-16 update, one data bit per shift.
   function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] data);
      logic [15:0] r;
      logic        fb;
      r = acc;
      for (int k = 0; k < 8; k++) begin
         fb = r[0] ^ data[k];
         r = r >> 1;
         if (fb) begin
            r = r ^ crcfr_pkg::CRC_POLY;
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] pick_byte();
      logic [7:0] v;
      case ($urandom_range(9))
         0: begin
            v = 8'h00;
         end
         1: begin
            v = 8'hFF;
         end
         2: begin
            v = crcfr_pkg::START_BYTE;
         end
         default: begin
            v = 8'($urandom_range(255));
         end
      endcase
      return v;
   endfunction

   task automatic deframe_byte(input logic [7:0] value, input logic line_err,
                               output bit produced, output crcfr_pkg::frame_type fr);
      produced = 1'b0;
      fr = '0;
      if (line_err) begin
         line_error_tally = line_error_tally + 16'd1;
         frame_pos = crcfr_pkg::POS_HUNT;
      end else if (frame_pos == crcfr_pkg::POS_HUNT || frame_pos > crcfr_pkg::POS_CRC_LO) begin
         if (value == crcfr_pkg::START_BYTE) begin
            frame_pos = crcfr_pkg::POS_HUNT + 4'd1;
            crc_acc = crcfr_pkg::CRC_INIT;
         end else begin
            frame_pos = crcfr_pkg::POS_HUNT;
            bad_start_tally = bad_start_tally + 16'd1;
         end
      end else if (frame_pos <= crcfr_pkg::POS_LAST_HDR) begin
         header_bits = {header_bits[39:0], value};
         crc_acc = crc16_step(crc_acc, value);
         frame_pos = frame_pos + 4'd1;
      end else if (frame_pos == crcfr_pkg::POS_CRC_HI) begin
         crc_hi_seen = value;
         frame_pos = crcfr_pkg::POS_CRC_LO;
      end else begin
         produced = 1'b1;
         fr = frame_of(header_bits[47:40], header_bits[39:32], header_bits[31:16],
                       header_bits[15:0], {crc_hi_seen, value} == crc_acc,
                       header_bits[47:40] == node_addr, bad_start_tally, line_error_tally);
         frame_pos = crcfr_pkg::POS_HUNT;
      end
   endtask

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %h expected %h", name, got, want));
      end
   endtask

   task automatic send_byte(input logic [7:0] value, input logic line_err,
                            input bit has_frame, input crcfr_pkg::frame_type typed);
      bit                   produced;
      crcfr_pkg::frame_type predicted;
      while ($urandom_range(99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.rx_byte <= value;
      req_ch.line_error <= line_err;
      do @(posedge clock); while (!req_ch.ready);
      bytes_sent++;
      deframe_byte(value, line_err, produced, predicted);
      if (has_frame && !produced) begin
         report_mismatch("directed row expects a frame that its byte does not complete");
      end
      if (produced) begin
         pending_frames.push_back(has_frame ? typed : predicted);
      end
   endtask

   task automatic push_byte(input logic [7:0] value, input logic line_err);
      send_byte(value, line_err, 1'b0, '0);
   endtask

   task automatic send_random_frame();
      int unsigned shape;
      int unsigned n;
      logic [7:0]  payload [6];
      logic [7:0]  hi;
      logic [7:0]  lo;
      shape = $urandom_range(99);
      if (shape < 72) begin
         payload[0] = ($urandom_range(2) == 0) ? node_addr : pick_byte();
         for (int k = 1; k < 6; k++) begin
            payload[k] = pick_byte();
         end
         push_byte(crcfr_pkg::START_BYTE, 1'b0);
         for (int k = 0; k < 6; k++) begin
            push_byte(payload[k], 1'b0);
         end
         hi = crc_acc[15:8];
         lo = crc_acc[7:0];
         if ($urandom_range(5) == 0) begin
            if ($urandom_range(1) == 0) begin
               hi = hi ^ 8'($urandom_range(255, 1));
            end else begin
               lo = lo ^ 8'($urandom_range(255, 1));
            end
         end
         push_byte(hi, 1'b0);
         push_byte(lo, 1'b0);
      end else if (shape < 82) begin
         n = $urandom_range(4, 1);
         repeat (n) push_byte(pick_byte(), $urandom_range(7) == 0);
      end else if (shape < 92) begin
         n = $urandom_range(7);
         push_byte(crcfr_pkg::START_BYTE, 1'b0);
         repeat (n) push_byte(pick_byte(), 1'b0);
         push_byte(8'($urandom_range(255)), 1'b1);
      end else begin
         n = $urandom_range(7);
         push_byte(crcfr_pkg::START_BYTE, 1'b0);
         repeat (n) push_byte(pick_byte(), 1'b0);
      end
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_node_address(input logic [7:0] value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      node_addr = value;
   endtask

   task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                            input bit with_stall);
      int unsigned start;
      send_gap_pct = send_pct;
      recv_gap_pct = recv_pct;
      start = bytes_sent;
      if (with_stall) begin
         stall_requests++;
      end
      while (bytes_sent - start < PHASE_BYTES) send_random_frame();
   endtask

   // Result sink: random back-pressure, plus a long hold-off whenever one is requested.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_requests != stalls_served) begin
            stalls_served++;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
      end
   end

   always @(posedge clock) begin : result_check
      crcfr_pkg::frame_type seen;
      crcfr_pkg::frame_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         seen = frame_of(rsp_ch.frame_address, rsp_ch.frame_command, rsp_ch.first_word,
                         rsp_ch.second_word, rsp_ch.crc_ok, rsp_ch.address_match,
                         rsp_ch.bad_start_count, rsp_ch.line_error_count);
         if (pending_frames.size() == 0) begin
            report_mismatch("frame result with none expected");
         end else begin
            want = pending_frames.pop_front();
            frames_checked++;
            if (!want.crc_ok) begin
               crc_fail_frames++;
            end
            if (want.address_match) begin
               addressed_frames++;
            end
            check_field("frame_address", 16'(seen.frame_address), 16'(want.frame_address));
            check_field("frame_command", 16'(seen.frame_command), 16'(want.frame_command));
            check_field("first_word", seen.first_word, want.first_word);
            check_field("second_word", seen.second_word, want.second_word);
            check_field("crc_ok", 16'(seen.crc_ok), 16'(want.crc_ok));
            check_field("address_match", 16'(seen.address_match), 16'(want.address_match));
            check_field("bad_start_count", seen.bad_start_count, want.bad_start_count);
            check_field("line_error_count", seen.line_error_count, want.line_error_count);
         end
      end
   end

   initial begin
      directed_row_type     rows[$];
      crcfr_pkg::frame_type frame_a;
      crcfr_pkg::frame_type frame_b;
      logic [7:0]           b;
      req_ch.valid <= 1'b0;
      req_ch.rx_byte <= '0;
      req_ch.line_error <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      send_gap_pct = 12;
      recv_gap_pct = 74;

      // A clean frame after reset with the node address at its reset value, a frame dropped
      // by a line error, and a frame with a bad CRC whose command is the start byte.
      frame_a = frame_of(8'h00, 8'hFF, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 16'd1, 16'd1);
      frame_b = frame_of(8'hFF, crcfr_pkg::START_BYTE, 16'hFFFF, 16'h0000, 1'b0, 1'b0,
                         16'd1, 16'd2);
      rows.push_back(mk_row(SRC_LITERAL, 8'hFF, 1'b0, 1'b0, '0));
      rows.push_back(mk_row(SRC_LITERAL, crcfr_pkg::START_BYTE, 1'b1, 1'b0, '0));
      rows.push_back(mk_row(SRC_LITERAL, crcfr_pkg::START_BYTE, 1'b0, 1'b0, '0));
      rows.push_back(mk_row(SRC_LITERAL, 8'h00, 1'b0, 1'b0, '0));
      rows.push_back(mk_row(SRC_LITERAL, 8'hFF, 1'b0, 1'b0, '0));
      rows.push_back(mk_row(SRC_LITERAL, 8'h00, 1'b0, 1'b0, '0));
      rows.push_back(mk_row(SRC_LITERAL, 8'h00, 1'b0, 1'b0, '0));
      rows.push_back(mk_row(SRC_LITERAL, 8'hFF, 1'b0, 1'b0, '0));
      rows.push_back(mk_row(SRC_LITERAL, 8'hFF, 1'b0, 1'b0, '0));
      rows.push_back(mk_row(SRC_CRC_HIGH, 8'h00, 1'b0, 1'b0, '0));
      rows.push_back(mk_row(SRC_CRC_LOW, 8'h00, 1'b0, 1'b1, frame_a));
      rows.push_back(mk_row(SRC_LITERAL, crcfr_pkg::START_BYTE, 1'b0, 1'b0, '0));
      rows.push_back(mk_row(SRC_LITERAL, crcfr_pkg::START_BYTE, 1'b0, 1'b0, '0));
      rows.push_back(mk_row(SRC_LITERAL, 8'h12, 1'b0, 1'b0, '0));
      rows.push_back(mk_row(SRC_LITERAL, 8'h00, 1'b1, 1'b0, '0));
      rows.push_back(mk_row(SRC_LITERAL, crcfr_pkg::START_BYTE, 1'b0, 1'b0, '0));
      rows.push_back(mk_row(SRC_LITERAL, 8'hFF, 1'b0, 1'b0, '0));
      rows.push_back(mk_row(SRC_LITERAL, crcfr_pkg::START_BYTE, 1'b0, 1'b0, '0));
      rows.push_back(mk_row(SRC_LITERAL, 8'hFF, 1'b0, 1'b0, '0));
      rows.push_back(mk_row(SRC_LITERAL, 8'hFF, 1'b0, 1'b0, '0));
      rows.push_back(mk_row(SRC_LITERAL, 8'h00, 1'b0, 1'b0, '0));
      rows.push_back(mk_row(SRC_LITERAL, 8'h00, 1'b0, 1'b0, '0));
      rows.push_back(mk_row(SRC_CRC_HIGH, 8'h00, 1'b0, 1'b0, '0));
      rows.push_back(mk_row(SRC_CRC_LOW_BAD, 8'h00, 1'b0, 1'b1, frame_b));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         case (rows[i].source)
            SRC_LITERAL: begin
               b = rows[i].value;
            end
            SRC_CRC_HIGH: begin
               b = crc_acc[15:8];
            end
            SRC_CRC_LOW: begin
               b = crc_acc[7:0];
            end
            default: begin
               b = crc_acc[7:0] ^ 8'h01;
            end
         endcase
         send_byte(b, rows[i].line_err, rows[i].has_frame, rows[i].frame);
      end

      write_node_address(8'hFF);
      run_phase(12, 74, 1'b1);
      write_node_address(8'($urandom_range(254, 1)));
      run_phase(74, 12, 1'b0);
      write_node_address(8'h00);
      run_phase(0, 0, 1'b1);

      write_node_address(crcfr_pkg::START_BYTE);
      repeat (16) send_random_frame();
      drain_results();

      $display("Covered %0d bytes and %0d checked frames, %0d with CRC errors and %0d",
               bytes_sent, frames_checked, crc_fail_frames, addressed_frames);
      $display("addressed to this node, over four node addresses, with noise and long stalls.");
      if (error_count == 0) begin
         $display("tb_crc_checked_frame_receiver: clean");
      end else begin
         $display("tb_crc_checked_frame_receiver: errors");
      end
      $finish;
   end

endmodule

>>> crc_checked_frame_receiver.f
hdl/crcfr_pkg.sv
hdl/crcfr_channels.sv
hdl/crcfr_deframer.sv
hdl/crcfr_out_stage.sv
hdl/crc_checked_frame_receiver.sv
tb/tb_crc_checked_frame_receiver.sv
